@@ hw/rtl/rlm_pkg.sv @@
package rlm_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int LEVEL_W         = 7;
	localparam int LEVEL_STEPS     = 100;
	localparam int SQ_W            = 31;
	localparam int MS_W            = 31;
	localparam int MAX_SAMPLES_DEF = 4096;

	localparam logic [63:0] ROM_C     = 64'd1026123955398;
	localparam logic [63:0] ROM_ONE   = 64'd1099511627776;
	localparam logic [63:0] ROM_FLOOR = 64'd109951163;

	typedef logic [MS_W-1:0] thr_t;
	typedef thr_t thr_rom_t [LEVEL_STEPS+1];

	// squared thresholds, Q30; r walks down from 1.0 in Q40 by ~10^-0.03 per step
	function automatic thr_rom_t build_thr_rom();
		logic [63:0] r;
		logic [63:0] d;
		logic [63:0] e;
		logic [63:0] sq;
		logic [63:0] ch;
		logic [63:0] cl;
		logic [63:0] p;
		thr_rom_t    t;
		r  = ROM_ONE;
		ch = ROM_C >> 20;
		cl = ROM_C & 64'hF_FFFF;
		t[0] = '0;
		for (int k = LEVEL_STEPS; k >= 1; k--) begin
			d  = (r > ROM_FLOOR) ? (r - ROM_FLOOR) : 64'd0;
			e  = (d + 64'd128) >> 8;
			sq = e * e;
			t[k] = MS_W'((sq >> 34) + {63'd0, |sq[33:0]});
			p  = r * ch + ((r * cl + (64'd1 << 19)) >> 20);
			r  = (p + (64'd1 << 19)) >> 20;
		end
		return t;
	endfunction

	localparam thr_rom_t THR_ROM = build_thr_rom();

endpackage

@@ hw/rtl/rlm_if.sv @@
interface rlm_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [rlm_pkg::SAMPLE_W-1:0] sample;
	logic                                last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rlm_out_if;
	logic                         valid;
	logic                         ready;
	logic [rlm_pkg::LEVEL_W-1:0]  level;
	logic                         overflow;

	modport source (output valid, output level, output overflow, input ready);
	modport sink   (input valid, input level, input overflow, output ready);
endinterface

@@ hw/rtl/rlm_cmpsub.sv @@
module rlm_cmpsub #(
	parameter int W = 32
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[W];
	assign diff = full[W-1:0];

endmodule

@@ hw/rtl/rms_level_meter_percent.sv @@
// A sample is captured, then squared and accumulated; a last sample then runs
// a bit-serial divide of sum by count and a binary threshold search before the
// result is registered; the search holds while the output register is full.
// Input waits until a sample is accumulated; division and search hold it off.
// One compare/subtract unit serves both the divider and the threshold search.
// Reset clears sum, count, overflow flag, sequencer and output valid.
module rms_level_meter_percent #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	rlm_in_if.sink          audio,
	rlm_out_if.source       meter
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = rlm_pkg::SQ_W - 1 + CNT_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int CMP_W  = (rlm_pkg::MS_W > CNT_W + 1) ? rlm_pkg::MS_W : CNT_W + 1;
	localparam int LW     = rlm_pkg::LEVEL_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;

	logic [2:0]                    state_q;
	logic [rlm_pkg::SAMPLE_W-1:0]  mag_q;
	logic                          last_q;
	logic [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          ovf_q;
	logic [CNT_W-1:0]              rem_q;
	logic [STEP_W-1:0]             step_q;
	logic [LW-1:0]                 lo_q;
	logic [LW-1:0]                 hi_q;
	logic                          out_vld_q;
	logic [LW-1:0]                 level_q;
	logic                          out_ovf_q;

	logic [rlm_pkg::SAMPLE_W-1:0]  mag;
	logic [2*rlm_pkg::SAMPLE_W-1:0] sq_full;
	logic [CNT_W:0]                rem_next;
	logic [LW:0]                   mid_sum;
	logic [LW-1:0]                 mid;
	logic [CMP_W-1:0]              cmp_a;
	logic [CMP_W-1:0]              cmp_b;
	logic                          cmp_ge;
	logic [CMP_W-1:0]              cmp_diff;
	logic                          srch_done;
	logic                          load_out;
	logic                          in_acc;

	assign mag      = audio.sample[rlm_pkg::SAMPLE_W-1] ? (~audio.sample + 1'b1) : audio.sample;
	assign sq_full  = mag_q * mag_q;
	assign rem_next = {rem_q, sum_q[SUM_W-1]};
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
	assign mid      = mid_sum[LW:1];

	always_comb begin
		if (state_q == ST_DIV) begin
			cmp_a = CMP_W'(rem_next);
			cmp_b = CMP_W'(cnt_q);
		end else begin
			cmp_a = CMP_W'(sum_q[rlm_pkg::MS_W-1:0]);
			cmp_b = CMP_W'(rlm_pkg::THR_ROM[mid]);
		end
	end

	rlm_cmpsub #(.W(CMP_W)) u_cmpsub (
		.a    (cmp_a),
		.b    (cmp_b),
		.ge   (cmp_ge),
		.diff (cmp_diff)
	);

	assign srch_done = (state_q == ST_SRCH) && (lo_q == hi_q);
	assign load_out  = srch_done && (!out_vld_q || meter.ready);
	assign in_acc    = audio.valid && audio.ready;

	assign audio.ready    = (state_q == ST_IDLE);
	assign meter.valid    = out_vld_q;
	assign meter.level    = level_q;
	assign meter.overflow = out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out)
				out_vld_q <= 1'b1;
			else if (meter.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cnt_q == CNT_W'(MAX_SAMPLES)) begin
						ovf_q <= 1'b1;
					end else begin
						sum_q <= sum_q + SUM_W'(sq_full[rlm_pkg::SQ_W-1:0]);
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= last_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					sum_q <= {sum_q[SUM_W-2:0], cmp_ge};
					if (step_q == STEP_W'(SUM_W - 1))
						state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (load_out) begin
						sum_q     <= '0;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q  <= mag;
			last_q <= audio.last;
		end
		case (state_q)
			ST_ACC: begin
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= cmp_ge ? cmp_diff[CNT_W-1:0] : rem_next[CNT_W-1:0];
				step_q <= step_q + 1'b1;
				lo_q   <= '0;
				hi_q   <= LW'(rlm_pkg::LEVEL_STEPS);
			end
			ST_SRCH: begin
				if (!srch_done) begin
					if (cmp_ge)
						lo_q <= mid;
					else
						hi_q <= mid - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			level_q   <= lo_q;
			out_ovf_q <= ovf_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond maximum");

	a_rem_lt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cnt_q))
		else $error("divider remainder not below count");

	a_srch_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (meter.valid && (meter.level <= LW'(rlm_pkg::LEVEL_STEPS))))
		else $error("result not presented after search");
`endif

endmodule

@@ tb/rms_level_meter_percent_tb.sv @@
`timescale 1ns / 1ps

module rms_level_meter_percent_tb;

	localparam int          MAX_N       = rlm_pkg::MAX_SAMPLES_DEF;
	localparam int          CYCLE_LIMIT = 600000;
	localparam int          DRAIN       = 80;
	localparam int          PHASE_ITEMS = 430;

	typedef struct packed {
		logic [rlm_pkg::LEVEL_W-1:0] level;
		logic                        overflow;
	} meter_reading_t;

	class level_scoreboard;
		logic [63:0]      thr [rlm_pkg::LEVEL_STEPS+1];
		logic [63:0]      sq_sum;
		int unsigned      n_acc;
		bit               over;
		meter_reading_t   due [$];
		int unsigned      errors;
		int unsigned      samples_in;
		int unsigned      buffers;
		int unsigned      ovf_buffers;
		int unsigned      lvl_min;
		int unsigned      lvl_max;

		function new();
			logic [63:0] r;
			logic [63:0] d;
			logic [63:0] e;
			logic [63:0] sq;
			logic [63:0] ch;
			logic [63:0] cl;
			logic [63:0] p;
			r  = rlm_pkg::ROM_ONE;
			ch = rlm_pkg::ROM_C >> 20;
			cl = rlm_pkg::ROM_C & 64'hF_FFFF;
			for (int k = rlm_pkg::LEVEL_STEPS; k >= 1; k--) begin
				d      = (r > rlm_pkg::ROM_FLOOR) ? (r - rlm_pkg::ROM_FLOOR) : 64'd0;
				e      = (d + 64'd128) >> 8;
				sq     = e * e;
				thr[k] = (sq >> 34) + ((sq[33:0] != 34'd0) ? 64'd1 : 64'd0);
				p      = r * ch + ((r * cl + (64'd1 << 19)) >> 20);
				r      = (p + (64'd1 << 19)) >> 20;
			end
			thr[0]      = '0;
			sq_sum      = '0;
			n_acc       = 0;
			over        = 1'b0;
			errors      = 0;
			samples_in  = 0;
			buffers     = 0;
			ovf_buffers = 0;
			lvl_min     = rlm_pkg::LEVEL_STEPS;
			lvl_max     = 0;
		endfunction

		function void note_sample(logic signed [rlm_pkg::SAMPLE_W-1:0] s, logic l);
			logic [16:0]     mag;
			logic [63:0]     mean_sq;
			int unsigned     lv;
			meter_reading_t  rd;
			samples_in++;
			mag = s[rlm_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
			if (n_acc < MAX_N) begin
				sq_sum = sq_sum + {47'd0, mag} * {47'd0, mag};
				n_acc++;
			end else begin
				over = 1'b1;
			end
			if (l) begin
				mean_sq = (n_acc != 0) ? (sq_sum / n_acc) : 64'd0;
				lv = 0;
				for (int k = 1; k <= rlm_pkg::LEVEL_STEPS; k++)
					if (mean_sq >= thr[k])
						lv = k;
				rd.level    = rlm_pkg::LEVEL_W'(lv);
				rd.overflow = over;
				due.push_back(rd);
				buffers++;
				if (over)
					ovf_buffers++;
				if (lv < lvl_min)
					lvl_min = lv;
				if (lv > lvl_max)
					lvl_max = lv;
				sq_sum = '0;
				n_acc  = 0;
				over   = 1'b0;
			end
		endfunction

		function void check_reading(logic [rlm_pkg::LEVEL_W-1:0] lv, logic ov);
			meter_reading_t exp_rd;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected reading level=%0d overflow=%0b", $realtime, lv, ov);
				return;
			end
			exp_rd = due.pop_front();
			if (exp_rd.level !== lv || exp_rd.overflow !== ov) begin
				errors++;
				if (errors <= 10)
					$display("%0t: reading mismatch: expected level=%0d overflow=%0b, got level=%0d overflow=%0b",
						$realtime, exp_rd.level, exp_rd.overflow, lv, ov);
			end
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rlm_in_if  audio_if ();
	rlm_out_if meter_if ();

	rms_level_meter_percent DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.audio  (audio_if),
		.meter  (meter_if)
	);

	level_scoreboard sb;
	int unsigned     send_idle;
	int unsigned     recv_idle;
	int unsigned     cycles;
	int unsigned     phase_items;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d readings outstanding", cycles, sb.pending());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		meter_if.ready = ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk)
		if (arst_n && meter_if.valid && meter_if.ready)
			sb.check_reading(meter_if.level, meter_if.overflow);

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(logic signed [rlm_pkg::SAMPLE_W-1:0] s, logic l);
		while ($urandom_range(0, 99) < send_idle) begin
			audio_if.valid = 1'b0;
			@(negedge clk);
		end
		audio_if.valid  = 1'b1;
		audio_if.sample = s;
		audio_if.last   = l;
		@(posedge clk);
		while (!audio_if.ready)
			@(posedge clk);
		sb.note_sample(s, l);
		phase_items++;
		@(negedge clk);
		audio_if.valid = 1'b0;
	endtask

	function automatic logic signed [rlm_pkg::SAMPLE_W-1:0] pick_sample(int kind, int b,
		logic [16:0] mag);
		logic [31:0] raw;
		int          v;
		raw = $urandom();
		case (kind)
			0: return raw[15:0];
			1: begin
				v = int'($urandom_range(0, (2 << b) - 1)) - (1 << b);
				return v[15:0];
			end
			2: begin
				if (mag == 17'h10000 || (mag == 17'h08000 && raw[0]))
					return 16'sh8000;
				v = raw[1] ? -int'(mag) : int'(mag);
				if (mag == 17'h08000)
					v = 32767;
				return v[15:0];
			end
			default: return (raw[4:0] == 5'd0) ? raw[31:16] : 16'sd0;
		endcase
	endfunction

	task automatic send_buffer(int len);
		int          kind;
		int          b;
		logic [16:0] mag;
		kind = $urandom_range(0, 3);
		b    = $urandom_range(0, 15);
		mag  = 17'($urandom_range(0, 32768) >> $urandom_range(0, 15));
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(kind, b, mag), i == len - 1);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int len;
		sb              = new();
		arst_n          = 1'b0;
		audio_if.valid  = 1'b0;
		audio_if.sample = '0;
		audio_if.last   = 1'b0;
		meter_if.ready  = 1'b0;
		cycles          = 0;
		send_idle       = 28;
		recv_idle       = 56;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-sample buffers at the extremes and in between, then short mixed buffers
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd32767, 1'b1);
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd33, 1'b1);
		send_sample(16'sd328, 1'b1);
		send_sample(-16'sd3277, 1'b1);
		send_sample(16'sd16384, 1'b0);
		send_sample(-16'sd16384, 1'b1);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd5, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(16'sh5555, 1'b0);
		send_sample(16'shAAAA, 1'b1);

		for (int p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 28 : (p == 1) ? 56 : 0;
			recv_idle = (p == 0) ? 56 : (p == 1) ? 28 : 0;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
				                                  : $urandom_range(1, 24);
				send_buffer(len);
			end
			// hold the sender until the meter has caught up
			wait_drained();
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end

		wait_drained();
		repeat (DRAIN) @(negedge clk);
		sb.errors += sb.pending();

		$display("Covered %0d samples in %0d buffers, %0d of them over the count limit,",
			sb.samples_in, sb.buffers, sb.ovf_buffers);
		$display("with levels from %0d to %0d under three idling mixes; %0d mismatches.",
			sb.lvl_min, sb.lvl_max, sb.errors);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
